### hw/rtl/akl_pkg.sv
package akl_pkg;

  // item actions
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;
  localparam logic [1:0] ACT_PHASE  = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOPING  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START    = 3'd4;
  localparam int unsigned CFG_DATA_W = 32;

  // field widths
  localparam int unsigned REL_W   = 34;
  localparam int unsigned TDUR_W  = 31;
  localparam int unsigned LEN_W   = 24;
  localparam int unsigned FRAME_W = 8;
  localparam int unsigned WGT_W   = 16;

  // saturation limits of the relative time
  localparam logic signed [REL_W-1:0] REL_MAX = {1'b0, {(REL_W-1){1'b1}}};
  localparam logic signed [REL_W-1:0] REL_MIN = {1'b1, {(REL_W-1){1'b0}}};

  // shared divider: up to 55-bit dividend over a 31-bit divisor
  localparam int unsigned DVD_W = 55;
  localparam int unsigned DVS_W = 31;
  localparam int unsigned DCNT_W = 6;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE       = 4'd0,
    OP_CAPTURE    = 4'd1,
    OP_CLAMP      = 4'd2,
    OP_PHASE      = 4'd3,
    OP_SET        = 4'd4,
    OP_LOAD       = 4'd5,
    OP_MOD_FIX    = 4'd6,
    OP_CLASS      = 4'd7,
    OP_FDIV_START = 4'd8,
    OP_FDIV_END   = 4'd9,
    OP_WALK0      = 4'd10,
    OP_WALK       = 4'd11,
    OP_WRAP_LOAD  = 4'd12,
    OP_WGT        = 4'd13,
    OP_WDIV_END   = 4'd14,
    OP_EMIT       = 4'd15
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic need_mod;
    logic at_end;
    logic at_start;
    logic fixed;
    logic div_done;
    logic walk_stop;
    logic walk_wrap;
    logic w_triv;
  } sts_t;

endpackage

### hw/rtl/akl_ifaces.sv
// request channel into the locator
interface akl_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic signed [31:0] abs_time;
  logic signed [23:0] phase_fraction;
  logic [7:0]        frame_index;
  logic [23:0]       frame_length;

  modport source (output valid, output action, output abs_time, output phase_fraction,
                  output frame_index, output frame_length, input ready);
  modport sink (input valid, input action, input abs_time, input phase_fraction,
                input frame_index, input frame_length, output ready);
endinterface

// result channel out of the locator
interface akl_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  current_frame;
  logic [7:0]  next_frame;
  logic [15:0] blend_weight;
  logic        moving_forward;

  modport source (output valid, output current_frame, output next_frame,
                  output blend_weight, output moving_forward, input ready);
  modport sink (input valid, input current_frame, input next_frame,
                input blend_weight, input moving_forward, output ready);
endinterface

### hw/rtl/akl_ram.sv
module akl_ram #(
  parameter int unsigned W = 24,
  parameter int unsigned D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/akl_div.sv
// restoring divider, one quotient bit per cycle
module akl_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [akl_pkg::DVD_W-1:0]   dividend,
  input  logic [akl_pkg::DVS_W-1:0]   divisor,
  output logic                        done,
  output logic [akl_pkg::DVD_W-1:0]   quotient,
  output logic [akl_pkg::DVS_W-1:0]   remainder
);

  localparam int unsigned DW = akl_pkg::DVD_W;
  localparam int unsigned SW = akl_pkg::DVS_W;
  localparam int unsigned CW = akl_pkg::DCNT_W;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] dvs_r, dvs_nxt;
  logic [SW:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[DW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when it fits
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = SW'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[SW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### hw/rtl/akl_ctrl.sv
// sequencer: steps one request through capture, wrap, locate and weight
module akl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_action,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  output akl_pkg::cmd_t       cmd,
  input  akl_pkg::sts_t       sts
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_UPD   = 16'h0002,
    S_PHS   = 16'h0004,
    S_SET   = 16'h0008,
    S_EVAL  = 16'h0010,
    S_MOD   = 16'h0020,
    S_CLS   = 16'h0040,
    S_FMUL  = 16'h0080,
    S_FDIV  = 16'h0100,
    S_WALK0 = 16'h0200,
    S_WALK  = 16'h0400,
    S_WRAPA = 16'h0800,
    S_WRAPB = 16'h1000,
    S_WGT   = 16'h2000,
    S_WDIV  = 16'h4000,
    S_FIN   = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = akl_pkg::OP_NONE;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = akl_pkg::OP_CAPTURE;
          unique case (in_action)
            akl_pkg::ACT_UPDATE: state_nxt = S_UPD;
            akl_pkg::ACT_PHASE:  state_nxt = S_PHS;
            default:             state_nxt = S_EVAL;
          endcase
        end
      end
      S_UPD: begin
        cmd.op    = akl_pkg::OP_CLAMP;
        state_nxt = S_SET;
      end
      S_PHS: begin
        cmd.op    = akl_pkg::OP_PHASE;
        state_nxt = S_SET;
      end
      S_SET: begin
        cmd.op    = akl_pkg::OP_SET;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.op    = akl_pkg::OP_LOAD;
        state_nxt = sts.need_mod ? S_MOD : S_CLS;
      end
      S_MOD: begin
        if (sts.div_done) begin
          cmd.op    = akl_pkg::OP_MOD_FIX;
          state_nxt = S_CLS;
        end
      end
      S_CLS: begin
        cmd.op = akl_pkg::OP_CLASS;
        if (sts.at_end || sts.at_start) begin
          state_nxt = S_FIN;
        end else if (sts.fixed) begin
          state_nxt = S_FMUL;
        end else begin
          state_nxt = S_WALK0;
        end
      end
      S_FMUL: begin
        cmd.op    = akl_pkg::OP_FDIV_START;
        state_nxt = S_FDIV;
      end
      S_FDIV: begin
        if (sts.div_done) begin
          cmd.op    = akl_pkg::OP_FDIV_END;
          state_nxt = S_FIN;
        end
      end
      S_WALK0: begin
        cmd.op    = akl_pkg::OP_WALK0;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        cmd.op = akl_pkg::OP_WALK;
        if (sts.walk_stop) begin
          state_nxt = sts.walk_wrap ? S_WRAPA : S_WGT;
        end
      end
      S_WRAPA: begin
        state_nxt = S_WRAPB;
      end
      S_WRAPB: begin
        cmd.op    = akl_pkg::OP_WRAP_LOAD;
        state_nxt = S_WGT;
      end
      S_WGT: begin
        cmd.op    = akl_pkg::OP_WGT;
        state_nxt = sts.w_triv ? S_FIN : S_WDIV;
      end
      S_WDIV: begin
        if (sts.div_done) begin
          cmd.op    = akl_pkg::OP_WDIV_END;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // hand over once the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.op        = akl_pkg::OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### hw/rtl/akl_dp.sv
// datapath: config, time state, duration table, divider and result registers
module akl_dp #(
  parameter int unsigned MAX_FRAMES = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [1:0]                         in_action,
  input  logic signed [31:0]                 in_abs_time,
  input  logic signed [23:0]                 in_phase_fraction,
  input  logic [7:0]                         in_frame_index,
  input  logic [23:0]                        in_frame_length,
  input  logic                               cfg_we,
  input  logic [akl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [akl_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  akl_pkg::cmd_t                      cmd,
  output akl_pkg::sts_t                      sts,
  output logic [7:0]                         out_current_frame,
  output logic [7:0]                         out_next_frame,
  output logic [15:0]                        out_blend_weight,
  output logic                               out_moving_forward
);

  localparam int unsigned AW  = $clog2(MAX_FRAMES);
  localparam int unsigned RW  = akl_pkg::REL_W;
  localparam int unsigned TW  = akl_pkg::TDUR_W;
  localparam int unsigned LW  = akl_pkg::LEN_W;
  localparam int unsigned DVW = akl_pkg::DVD_W;
  // cumulative duration width, never narrower than a wrapped time
  localparam int unsigned DW  = (AW + LW > TW) ? AW + LW : TW;

  // configuration
  logic                   loop_r, loop_nxt;
  logic                   fixed_r, fixed_nxt;
  logic [TW-1:0]          td_r, td_nxt;
  logic [7:0]             lf_r, lf_nxt;
  logic signed [31:0]     start_r, start_nxt;

  // time state
  logic signed [RW-1:0]   rel_r, rel_nxt;
  logic                   dir_r, dir_nxt;

  // per-request working registers
  logic signed [31:0]     abs_r, abs_nxt;
  logic signed [55:0]     mul_r, mul_nxt;
  logic signed [RW-1:0]   cand_r, cand_nxt;
  logic signed [RW-1:0]   time_r, time_nxt;
  logic [TW+7:0]          mul2_r, mul2_nxt;
  logic [AW-1:0]          cur_r, cur_nxt;
  logic [AW-1:0]          raddr_r, raddr_nxt;
  logic [DW-1:0]          dur_r, dur_nxt;
  logic [LW-1:0]          len_r, len_nxt;
  logic [7:0]             rcur_r, rcur_nxt;
  logic [7:0]             rnxt_r, rnxt_nxt;
  logic [15:0]            rw_r, rw_nxt;

  // result registers
  logic [7:0]             oc_r, oc_nxt;
  logic [7:0]             on_r, on_nxt;
  logic [15:0]            ow_r, ow_nxt;
  logic                   of_r, of_nxt;

  // table and divider hookup
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [LW-1:0]          ram_rdata;
  logic [31:0]            idx32;
  logic                   div_start;
  logic [DVW-1:0]         div_dvd;
  logic [TW-1:0]          div_dvs;
  logic                   div_done;
  logic [DVW-1:0]         div_quo;
  logic [TW-1:0]          div_rem;

  // helpers
  logic [TW-1:0]          tdur;
  logic signed [RW-1:0]   tdur_s;
  logic signed [RW-1:0]   t34, s34, hi34, tc;
  logic signed [39:0]     shq;
  logic [RW-1:0]          mag;
  logic [DW-1:0]          time_dw;
  logic [DW-1:0]          dur_new;
  logic [DW-1:0]          diff;
  logic                   last_idx;
  logic                   cur_is_lf;
  logic [31:0]            cur_p1;
  logic                   need_mod;
  logic                   w_triv;

  assign tdur     = (td_r == '0) ? TW'(1) : td_r;
  assign tdur_s   = $signed({{(RW-TW){1'b0}}, tdur});
  assign t34      = RW'(abs_r);
  assign s34      = RW'(start_r);
  assign hi34     = s34 + tdur_s;
  assign shq      = mul_r[55:16];
  assign mag      = rel_r[RW-1] ? RW'(-rel_r) : RW'(rel_r);
  assign time_dw  = DW'(time_r[TW-1:0]);
  assign dur_new  = dur_r + DW'(ram_rdata);
  assign diff     = time_dw - dur_r;
  assign last_idx = (32'(cur_r) == 32'(MAX_FRAMES - 1));
  assign cur_is_lf = (32'(cur_r) == 32'(lf_r));
  assign cur_p1   = 32'(cur_r) + 32'd1;
  assign need_mod = loop_r && (rel_r >= tdur_s || rel_r[RW-1]);
  assign w_triv   = (time_dw <= dur_r) || (len_r == '0);
  assign idx32    = 32'(in_frame_index);

  // status to the controller
  always_comb begin
    sts.need_mod  = need_mod;
    sts.at_end    = !loop_r && (time_r >= tdur_s);
    sts.at_start  = !loop_r && (time_r[RW-1] || time_r == '0);
    sts.fixed     = fixed_r;
    sts.div_done  = div_done;
    sts.walk_stop = !(time_dw > dur_new) || last_idx;
    sts.walk_wrap = cur_is_lf;
    sts.w_triv    = w_triv;
  end

  // table write on a captured write request
  assign ram_we    = (cmd.op == akl_pkg::OP_CAPTURE) && (in_action == akl_pkg::ACT_WRITE) &&
                     (idx32 < 32'(MAX_FRAMES));
  assign ram_waddr = idx32[AW-1:0];

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_dvd   = DVW'(mag);
    div_dvs   = tdur;
    unique case (cmd.op)
      akl_pkg::OP_LOAD: begin
        div_start = need_mod;
      end
      akl_pkg::OP_FDIV_START: begin
        div_start = 1'b1;
        div_dvd   = DVW'({mul2_r, 16'b0});
      end
      akl_pkg::OP_WGT: begin
        div_start = !w_triv;
        div_dvd   = DVW'({diff[TW-1:0], 16'b0});
        div_dvs   = TW'(len_r);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    loop_nxt  = loop_r;
    fixed_nxt = fixed_r;
    td_nxt    = td_r;
    lf_nxt    = lf_r;
    start_nxt = start_r;
    rel_nxt   = rel_r;
    dir_nxt   = dir_r;
    abs_nxt   = abs_r;
    mul_nxt   = mul_r;
    cand_nxt  = cand_r;
    time_nxt  = time_r;
    mul2_nxt  = mul2_r;
    cur_nxt   = cur_r;
    raddr_nxt = raddr_r;
    dur_nxt   = dur_r;
    len_nxt   = len_r;
    rcur_nxt  = rcur_r;
    rnxt_nxt  = rnxt_r;
    rw_nxt    = rw_r;
    oc_nxt    = oc_r;
    on_nxt    = on_r;
    ow_nxt    = ow_r;
    of_nxt    = of_r;
    tc        = t34;

    // register writes
    if (cfg_we) begin
      unique case (cfg_index)
        akl_pkg::CFG_LOOPING: loop_nxt  = cfg_data[0];
        akl_pkg::CFG_FIXED:   fixed_nxt = cfg_data[0];
        akl_pkg::CFG_TOTAL:   td_nxt    = cfg_data[TW-1:0];
        akl_pkg::CFG_LAST:    lf_nxt    = cfg_data[7:0];
        akl_pkg::CFG_START:   start_nxt = $signed(cfg_data);
        default: begin
        end
      endcase
    end

    unique case (cmd.op)
      akl_pkg::OP_CAPTURE: begin
        abs_nxt = in_abs_time;
        mul_nxt = 56'(in_phase_fraction) * 56'($signed({1'b0, tdur}));
      end
      akl_pkg::OP_CLAMP: begin
        // clamp to the clip when not looping
        if (!loop_r) begin
          if (t34 > hi34) begin
            tc = hi34;
          end else if (t34 < s34) begin
            tc = s34;
          end
        end
        cand_nxt = tc - s34;
      end
      akl_pkg::OP_PHASE: begin
        // floor of the scaled phase, saturated to the time range
        if (shq[39:RW-1] != {(41-RW){shq[39]}}) begin
          cand_nxt = shq[39] ? akl_pkg::REL_MIN : akl_pkg::REL_MAX;
        end else begin
          cand_nxt = shq[RW-1:0];
        end
      end
      akl_pkg::OP_SET: begin
        if (cand_r != rel_r) begin
          dir_nxt = (cand_r > rel_r);
          rel_nxt = cand_r;
        end
      end
      akl_pkg::OP_LOAD: begin
        time_nxt = rel_r;
      end
      akl_pkg::OP_MOD_FIX: begin
        if (rel_r[RW-1] && div_rem != '0) begin
          time_nxt = $signed(RW'(tdur - div_rem));
        end else begin
          time_nxt = $signed(RW'(div_rem));
        end
      end
      akl_pkg::OP_CLASS: begin
        rcur_nxt  = '0;
        rnxt_nxt  = '0;
        rw_nxt    = '0;
        if (!loop_r && time_r >= tdur_s) begin
          rcur_nxt = lf_r;
          rnxt_nxt = lf_r;
        end
        mul2_nxt  = (TW+8)'(time_r[TW-1:0]) * (TW+8)'(lf_r);
        cur_nxt   = '0;
        raddr_nxt = '0;
        dur_nxt   = '0;
      end
      akl_pkg::OP_FDIV_END: begin
        rcur_nxt = div_quo[23:16];
        rnxt_nxt = div_quo[23:16] + 8'd1;
        rw_nxt   = div_quo[15:0];
      end
      akl_pkg::OP_WALK0: begin
        raddr_nxt = AW'(1);
      end
      akl_pkg::OP_WALK: begin
        if (!(time_dw > dur_new) || last_idx) begin
          len_nxt = ram_rdata;
          if (cur_is_lf) begin
            // last keyframe wraps to the first pair
            rcur_nxt  = 8'd0;
            rnxt_nxt  = 8'd1;
            raddr_nxt = '0;
          end else begin
            rcur_nxt = 8'(32'(cur_r));
            rnxt_nxt = cur_p1[7:0];
          end
        end else begin
          dur_nxt   = dur_new;
          cur_nxt   = cur_r + AW'(1);
          raddr_nxt = (32'(raddr_r) == 32'(MAX_FRAMES - 1)) ? '0 : raddr_r + AW'(1);
        end
      end
      akl_pkg::OP_WRAP_LOAD: begin
        len_nxt = ram_rdata;
      end
      akl_pkg::OP_WGT: begin
        if (time_dw <= dur_r) begin
          rw_nxt = '0;
        end else if (len_r == '0) begin
          rw_nxt = 16'hFFFF;
        end
      end
      akl_pkg::OP_WDIV_END: begin
        rw_nxt = (div_quo[DVW-1:16] != '0) ? 16'hFFFF : div_quo[15:0];
      end
      akl_pkg::OP_EMIT: begin
        oc_nxt = rcur_r;
        on_nxt = rnxt_r;
        ow_nxt = rw_r;
        of_nxt = dir_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_r  <= 1'b0;
      fixed_r <= 1'b0;
      td_r    <= TW'(1);
      lf_r    <= '0;
      start_r <= '0;
      rel_r   <= '0;
      dir_r   <= 1'b0;
    end else begin
      loop_r  <= loop_nxt;
      fixed_r <= fixed_nxt;
      td_r    <= td_nxt;
      lf_r    <= lf_nxt;
      start_r <= start_nxt;
      rel_r   <= rel_nxt;
      dir_r   <= dir_nxt;
    end
    abs_r   <= abs_nxt;
    mul_r   <= mul_nxt;
    cand_r  <= cand_nxt;
    time_r  <= time_nxt;
    mul2_r  <= mul2_nxt;
    cur_r   <= cur_nxt;
    raddr_r <= raddr_nxt;
    dur_r   <= dur_nxt;
    len_r   <= len_nxt;
    rcur_r  <= rcur_nxt;
    rnxt_r  <= rnxt_nxt;
    rw_r    <= rw_nxt;
    oc_r    <= oc_nxt;
    on_r    <= on_nxt;
    ow_r    <= ow_nxt;
    of_r    <= of_nxt;
  end

  akl_ram #(
    .W(LW),
    .D(MAX_FRAMES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_frame_length),
    .raddr(raddr_r),
    .rdata(ram_rdata)
  );

  akl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  assign out_current_frame  = oc_r;
  assign out_next_frame     = on_r;
  assign out_blend_weight   = ow_r;
  assign out_moving_forward = of_r;

endmodule

### hw/rtl/animation_keyframe_locator_unit.sv
// Keyframe locator: each request (table write, absolute time update or phase
// set) yields one result with the current and next keyframe, a Q0.16 blend
// weight and the playback direction. One request is in flight at a time;
// a new one is taken while the previous result still waits on the output.
// The time per request depends on the shared 55-step radix-2 divider and the
// duration table walk over its single read port: clip-end results use
// neither, fixed-rate mode uses one divide (plus the wrap divide when a
// looping clip needs it), and table mode walks the table (one
// table entry per cycle, plus one divide each for the loop wrap and the
// weight). Table entries must be written before a walk reads them.
module animation_keyframe_locator_unit #(
  parameter int unsigned MAX_FRAMES = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  akl_in_if.sink                          in_if,
  akl_out_if.source                       out_if,
  input  logic                            cfg_we,
  input  logic [akl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [akl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  akl_pkg::cmd_t cmd;
  akl_pkg::sts_t sts;

  // sequencer
  akl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_action(in_if.action),
    .in_ready (in_if.ready),
    .out_ready(out_if.ready),
    .out_valid(out_if.valid),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath
  akl_dp #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_action         (in_if.action),
    .in_abs_time       (in_if.abs_time),
    .in_phase_fraction (in_if.phase_fraction),
    .in_frame_index    (in_if.frame_index),
    .in_frame_length   (in_if.frame_length),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .sts               (sts),
    .out_current_frame (out_if.current_frame),
    .out_next_frame    (out_if.next_frame),
    .out_blend_weight  (out_if.blend_weight),
    .out_moving_forward(out_if.moving_forward)
  );

  // a taken request always leaves the idle state
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("locator still ready after taking a request");

  // reset returns the sequencer to idle
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_if.ready)
    else $error("locator not ready after reset");

  // an emitted result is presented on the output
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == akl_pkg::OP_EMIT) |=> out_if.valid)
    else $error("result emitted but output not valid");

  // the divider only finishes while a request is in flight
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> !in_if.ready)
    else $error("divider finished while idle");

endmodule
